[rtl/gfsk_fb_pkg.sv]
// ----------------------------------------------------------------------------
// gfsk_fb_pkg
// Shared types, constants and the CRC-16-CCITT byte update for the framer.
// ----------------------------------------------------------------------------
package gfsk_fb_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [4:0] PREAMBLE_MAX = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] REG_PREAMBLE_COUNT = 2'd0;
  localparam logic [1:0] REG_PREAMBLE_VALUE = 2'd1;
  localparam logic [1:0] REG_SYNC_PATTERN   = 2'd2;

  localparam logic [4:0]  RST_PREAMBLE_COUNT = 5'd8;
  localparam logic [7:0]  RST_PREAMBLE_VALUE = 8'hAA;
  localparam logic [15:0] RST_SYNC_PATTERN   = 16'h2DD4;

  // One classified body byte on its way from front to back
  typedef struct packed {
    logic [7:0]  body_byte;
    logic [7:0]  frame_type;
    logic        hdr;    // first body byte of a frame: header goes out first
    logic        fin;    // last body byte: CRC trailer follows
    logic [15:0] crc;    // CRC after this byte
  } q_entry_t;

  // Live configuration as seen by the back end
  typedef struct packed {
    logic [4:0]  pre_count;   // already clamped to PREAMBLE_MAX
    logic [7:0]  pre_value;
    logic [15:0] sync;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_SYNC_HI,
    PH_SYNC_LO,
    PH_TYPE,
    PH_BODY,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  // MSB-first CRC update over one byte, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/gfsk_fb_front.sv]
// ----------------------------------------------------------------------------
// gfsk_fb_front
// Accept body bytes, mark frame starts and ends, and run the frame CRC.
// ----------------------------------------------------------------------------
module gfsk_fb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            body_byte,
  input  logic [7:0]            frame_type,
  input  logic                  body_final,
  output logic                  q_push,
  output gfsk_fb_pkg::q_entry_t q_entry,
  input  logic                  q_full
);
  import gfsk_fb_pkg::*;

  logic        in_frame;
  logic [15:0] crc;
  logic [15:0] crc_start;
  logic [15:0] crc_after;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Type byte seeds the CRC on the first body byte of a frame
  assign crc_start = in_frame ? crc : crc_byte(CRC_INIT, frame_type);
  assign crc_after = crc_byte(crc_start, body_byte);

  always_comb begin
    q_entry.body_byte  = body_byte;
    q_entry.frame_type = frame_type;
    q_entry.hdr        = !in_frame;
    q_entry.fin        = body_final;
    q_entry.crc        = crc_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      crc      <= CRC_INIT;
    end else if (q_push) begin
      in_frame <= !body_final;
      crc      <= body_final ? CRC_INIT : crc_after;
    end
  end

endmodule

[rtl/gfsk_fb_queue.sv]
// ----------------------------------------------------------------------------
// gfsk_fb_queue
// Short FIFO of classified body bytes between front and back.
// ----------------------------------------------------------------------------
module gfsk_fb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  gfsk_fb_pkg::q_entry_t wr_entry,
  output logic                  full,
  input  logic                  rd,
  output gfsk_fb_pkg::q_entry_t head,
  output logic                  head_valid
);
  import gfsk_fb_pkg::*;

  q_entry_t          slots [QDEPTH];
  logic [QAW-1:0]    wptr;
  logic [QAW-1:0]    rptr;
  logic [QAW:0]      count;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH)) else $error("queue count above depth");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    rd |-> head_valid) else $error("queue read while empty");

endmodule

[rtl/gfsk_fb_back.sv]
// ----------------------------------------------------------------------------
// gfsk_fb_back
// Expand each queued body byte into wire bytes and hold them for the consumer.
// ----------------------------------------------------------------------------
module gfsk_fb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  gfsk_fb_pkg::cfg_t     cfg,
  input  gfsk_fb_pkg::q_entry_t head,
  input  logic                  head_valid,
  output logic                  head_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            wire_byte,
  output logic                  run_end,
  output logic                  frame_end
);
  import gfsk_fb_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  phase_t     cur_ph;
  phase_t     ph_after;
  q_entry_t   cur;
  q_entry_t   src;
  logic [4:0] pre_rem;
  logic [4:0] rem_cur;
  logic       advance;
  logic       out_valid;
  logic [7:0] byte_sel;

  assign empty    = !out_valid;
  assign advance  = (phase != PH_IDLE || head_valid) && (!out_valid || pop);
  assign head_pop = advance && (phase == PH_IDLE);

  // Next state: work from the queue head when idle, else from the held entry
  always_comb begin
    src     = (phase == PH_IDLE) ? head : cur;
    rem_cur = (phase == PH_IDLE) ? cfg.pre_count : pre_rem;
    if (phase == PH_IDLE) begin
      if (head.hdr) begin
        cur_ph = (cfg.pre_count != '0) ? PH_PRE : PH_SYNC_HI;
      end else begin
        cur_ph = PH_BODY;
      end
    end else begin
      cur_ph = phase;
    end
    case (cur_ph)
      PH_PRE:     ph_after = (rem_cur == 5'd1) ? PH_SYNC_HI : PH_PRE;
      PH_SYNC_HI: ph_after = PH_SYNC_LO;
      PH_SYNC_LO: ph_after = PH_TYPE;
      PH_TYPE:    ph_after = PH_BODY;
      PH_BODY:    ph_after = src.fin ? PH_CRC_HI : PH_IDLE;
      PH_CRC_HI:  ph_after = PH_CRC_LO;
      default:    ph_after = PH_IDLE;
    endcase
    phase_next = advance ? ph_after : phase;
  end

  // Outputs: byte for the phase being emitted
  always_comb begin
    case (cur_ph)
      PH_PRE:     byte_sel = cfg.pre_value;
      PH_SYNC_HI: byte_sel = cfg.sync[15:8];
      PH_SYNC_LO: byte_sel = cfg.sync[7:0];
      PH_TYPE:    byte_sel = src.frame_type;
      PH_CRC_HI:  byte_sel = src.crc[15:8];
      PH_CRC_LO:  byte_sel = src.crc[7:0];
      default:    byte_sel = src.body_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur <= head;
    end
    if (advance) begin
      pre_rem   <= rem_cur - 5'd1;
      wire_byte <= byte_sel;
      run_end   <= (ph_after == PH_IDLE);
      frame_end <= (cur_ph == PH_CRC_LO);
    end
  end

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_end) else $error("frame end without run end");

  a_pre_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PRE |-> pre_rem != '0) else $error("preamble phase with no bytes left");

endmodule

[rtl/gfsk_frame_builder_crc16.sv]
// ----------------------------------------------------------------------------
// gfsk_frame_builder_crc16
// Preamble/sync framer with CRC-16-CCITT trailer (init FFFF, poly 1021).
// ----------------------------------------------------------------------------
//
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------
// input     | push / full            | body_byte, frame_type, body_final
// result    | empty / pop            | wire_byte, run_end, frame_end
// config    | cfg_write (no wait)    | cfg_index, cfg_data
//
// A pass-through body byte gives one wire byte; the back side emits one wire
// byte per clock while the consumer keeps popping. A frame start adds the
// preamble bytes, the two sync bytes and the type byte as header, and the
// final byte adds two CRC bytes. The front accepts one item per clock until the
// four-entry queue fills. Reset (rst, synchronous) empties the queue and the
// output register and puts the CRC back to FFFF outside a frame.
// ----------------------------------------------------------------------------
module gfsk_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  body_byte,
  input  logic [7:0]  frame_type,
  input  logic        body_final,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  wire_byte,
  output logic        run_end,
  output logic        frame_end,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gfsk_fb_pkg::*;

  logic [4:0]  preamble_count;
  logic [7:0]  preamble_value;
  logic [15:0] sync_pattern;
  cfg_t        cfg;

  logic        q_push;
  q_entry_t    q_entry;
  logic        q_full;
  logic        q_pop;
  q_entry_t    q_head;
  logic        q_head_valid;

  // Configuration registers; unknown index drops the write
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_count <= RST_PREAMBLE_COUNT;
      preamble_value <= RST_PREAMBLE_VALUE;
      sync_pattern   <= RST_SYNC_PATTERN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PREAMBLE_COUNT: preamble_count <= cfg_data[4:0];
        REG_PREAMBLE_VALUE: preamble_value <= cfg_data[7:0];
        REG_SYNC_PATTERN:   sync_pattern   <= cfg_data;
        default:            preamble_count <= preamble_count;
      endcase
    end
  end

  // Clamp oversized preamble counts to the maximum
  always_comb begin
    cfg.pre_count = (preamble_count > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_count;
    cfg.pre_value = preamble_value;
    cfg.sync      = sync_pattern;
  end

  // Front: accept, classify, advance the CRC
  gfsk_fb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .body_byte  (body_byte),
    .frame_type (frame_type),
    .body_final (body_final),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_full     (q_full)
  );

  // Queue: lets front and back stall independently
  gfsk_fb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_push),
    .wr_entry   (q_entry),
    .full       (q_full),
    .rd         (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // Back: expand each entry into wire bytes, hold the result register
  gfsk_fb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .head_valid (q_head_valid),
    .head_pop   (q_pop),
    .empty      (empty),
    .pop        (pop),
    .wire_byte  (wire_byte),
    .run_end    (run_end),
    .frame_end  (frame_end)
  );

endmodule

[tb/frame_wire_checker.sv]
// ----------------------------------------------------------------------------
// frame_wire_checker
// Watches the body, wire and register channels of the framer, builds the
// expected wire bytes for every accepted body byte and compares each popped
// wire byte against the oldest one due.
// ----------------------------------------------------------------------------
module frame_wire_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  body_byte,
  input  logic [7:0]  frame_type,
  input  logic        body_final,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  wire_byte,
  input  logic        run_end,
  input  logic        frame_end,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatch_count,
  output int unsigned beats_due
);
  import gfsk_fb_pkg::*;

  typedef struct packed {
    logic [7:0] wbyte;
    logic       item_last;
    logic       frame_last;
  } wire_beat_t;

  wire_beat_t  due_q[$];
  int unsigned fails = 0;

  // Shadow registers and framing state
  logic [4:0]  pre_count_r = RST_PREAMBLE_COUNT;
  logic [7:0]  pre_value_r = RST_PREAMBLE_VALUE;
  logic [15:0] sync_r      = RST_SYNC_PATTERN;
  logic        in_frame_r  = 1'b0;
  logic [15:0] crc_r       = CRC_INIT;

  // Bit-serial CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                 input logic [7:0]  data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ data[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Queue every wire byte caused by one body byte
  task automatic frame_body_byte(input logic [7:0] body, input logic [7:0] ftype,
                                 input logic fin);
    logic [8:0]  run[$];   // {frame_last, byte}
    int unsigned n_pre;
    wire_beat_t  beat;
    if (!in_frame_r) begin
      n_pre = 32'((pre_count_r > PREAMBLE_MAX) ? PREAMBLE_MAX : pre_count_r);
      repeat (n_pre) run.push_back({1'b0, pre_value_r});
      run.push_back({1'b0, sync_r[15:8]});
      run.push_back({1'b0, sync_r[7:0]});
      run.push_back({1'b0, ftype});
      crc_r      = crc_ccitt_step(CRC_INIT, ftype);
      in_frame_r = 1'b1;
    end
    run.push_back({1'b0, body});
    crc_r = crc_ccitt_step(crc_r, body);
    if (fin) begin
      run.push_back({1'b0, crc_r[15:8]});
      run.push_back({1'b1, crc_r[7:0]});
      crc_r      = CRC_INIT;
      in_frame_r = 1'b0;
    end
    for (int i = 0; i < run.size(); i++) begin
      beat.wbyte      = run[i][7:0];
      beat.frame_last = run[i][8];
      beat.item_last  = (i == run.size() - 1);
      due_q.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    wire_beat_t want;
    if (rst) begin
      due_q.delete();
      pre_count_r = RST_PREAMBLE_COUNT;
      pre_value_r = RST_PREAMBLE_VALUE;
      sync_r      = RST_SYNC_PATTERN;
      in_frame_r  = 1'b0;
      crc_r       = CRC_INIT;
    end else begin
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          $display("%0t: wire byte with nothing due: expected none, got %02h",
                   $time, wire_byte);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (wire_byte !== want.wbyte) begin
            $display("%0t: wire_byte expected %02h got %02h", $time, want.wbyte, wire_byte);
            fails++;
          end
          if (run_end !== want.item_last) begin
            $display("%0t: run_end expected %0b got %0b", $time, want.item_last, run_end);
            fails++;
          end
          if (frame_end !== want.frame_last) begin
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_last,
                     frame_end);
            fails++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PREAMBLE_COUNT: pre_count_r = cfg_data[4:0];
          REG_PREAMBLE_VALUE: pre_value_r = cfg_data[7:0];
          REG_SYNC_PATTERN:   sync_r      = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        frame_body_byte(body_byte, frame_type, body_final);
      end
    end
    beats_due      <= due_q.size();
    mismatch_count <= fails;
  end

endmodule

[tb/gfsk_frame_builder_crc16_tb.sv]
// ----------------------------------------------------------------------------
// gfsk_frame_builder_crc16_tb
// Drives body bytes and register writes into the framer, pops wire bytes
// under a changing stall pattern and lets frame_wire_checker judge them.
// ----------------------------------------------------------------------------
module gfsk_frame_builder_crc16_tb;
  import gfsk_fb_pkg::*;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 25;
  // Longest run of wire bytes one body byte can cause, plus queue slack
  localparam int unsigned SETTLE      = 40;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic        full;
  logic [7:0]  body_byte  = 8'h00;
  logic [7:0]  frame_type = 8'h00;
  logic        body_final = 1'b0;
  logic        empty;
  logic        pop        = 1'b0;
  logic [7:0]  wire_byte;
  logic        run_end;
  logic        frame_end;
  logic        cfg_write  = 1'b0;
  logic [1:0]  cfg_index  = REG_PREAMBLE_COUNT;
  logic [15:0] cfg_data   = 16'h0000;

  int unsigned mismatch_count;
  int unsigned beats_due;

  // Sender burst bookkeeping and random frame length tracker
  int unsigned burst_left = 0;
  int unsigned frame_left = 0;

  // Receiver stall pattern: rotate a 16-bit mask, pick a new one now and then
  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;

  always #2 clk = ~clk;

  gfsk_frame_builder_crc16 DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .body_byte  (body_byte),
    .frame_type (frame_type),
    .body_final (body_final),
    .empty      (empty),
    .pop        (pop),
    .wire_byte  (wire_byte),
    .run_end    (run_end),
    .frame_end  (frame_end),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frame_wire_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .body_byte      (body_byte),
    .frame_type     (frame_type),
    .body_final     (body_final),
    .empty          (empty),
    .pop            (pop),
    .wire_byte      (wire_byte),
    .run_end        (run_end),
    .frame_end      (frame_end),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .beats_due      (beats_due)
  );

  // Receiver: pop follows the low bit of the rotating mask. Masks range from
  // all ones (no stalls at all) down to a single one (long stalls).
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= pop_pattern[0];
      if (pattern_age == 0) begin
        pattern_age <= $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: pop_pattern <= 16'hFFFF;
          1: pop_pattern <= 16'($urandom_range(0, 65535) | 16'h0001);
          2: pop_pattern <= 16'($urandom_range(0, 65535) | $urandom_range(0, 65535)
                                | 16'h0001);
          default: pop_pattern <= 16'(($urandom_range(0, 65535) & $urandom_range(0, 65535))
                                      | 16'h0001);
        endcase
      end else begin
        pattern_age <= pattern_age - 1;
        pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
      end
    end
  end

  // Offer one body byte and hold it until the transaction completes. Between
  // bursts, drop push for a random gap; some bursts are long with no gaps.
  task automatic send_item(input logic [7:0] b, input logic [7:0] t, input logic f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    body_byte  <= b;
    frame_type <= t;
    body_final <= f;
    push       <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // Write all three registers back to back, optionally hitting the unused
  // index too, then drop the write enable once.
  task automatic program_regs(input logic [15:0] cnt_d, input logic [15:0] val_d,
                              input logic [15:0] sync_d, input logic hit_unused);
    cfg_write <= 1'b1;
    cfg_index <= REG_PREAMBLE_COUNT;
    cfg_data  <= cnt_d;
    @(posedge clk);
    cfg_index <= REG_PREAMBLE_VALUE;
    cfg_data  <= val_d;
    @(posedge clk);
    cfg_index <= REG_SYNC_PATTERN;
    cfg_data  <= sync_d;
    @(posedge clk);
    if (hit_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 16'($urandom_range(0, 65535));
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Stop offering and advance until every predicted wire byte was popped.
  // Every body byte causes at least one wire byte, so the framer is idle then.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
  endtask

  // Random frames: mostly short, some medium, a few long
  task automatic send_random_item();
    if (frame_left == 0) begin
      case ($urandom_range(0, 19))
        0:                frame_left = $urandom_range(13, 40);
        1, 2, 3, 4, 5:    frame_left = $urandom_range(5, 12);
        default:          frame_left = $urandom_range(1, 4);
      endcase
    end
    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), frame_left == 1);
    frame_left--;
  endtask

  initial begin
    logic [15:0] cnt_d;
    logic [15:0] val_d;
    logic [15:0] sync_d;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: single-byte body gives header, body and CRC at once
    send_item(8'h00, 8'h00, 1'b1);
    // Three-byte frame; the type on later bytes must be ignored
    send_item(8'hFF, 8'hFF, 1'b0);
    send_item(8'h80, 8'h00, 1'b0);
    send_item(8'h01, 8'h5A, 1'b1);

    // No preamble, all-zero sync; the unused index must not disturb anything
    wait_drained();
    program_regs(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(8'hA5, 8'h5A, 1'b1);
    send_item(8'h00, 8'hFF, 1'b0);
    send_item(8'hFF, 8'h00, 1'b1);

    // Full preamble on a single-byte body: the longest run of wire bytes
    wait_drained();
    program_regs(16'd16, 16'h00FF, 16'hFFFF, 1'b0);
    send_item(8'h7E, 8'h81, 1'b1);

    // Wide write data: the count keeps 31 and clamps to 16, the value keeps 8'h12
    wait_drained();
    program_regs(16'hFFFF, 16'hAB12, 16'h8001, 1'b1);
    send_item(8'hC3, 8'h3C, 1'b1);
    send_item(8'h01, 8'h02, 1'b0);

    // Registers change mid-frame: the open frame ends unchanged, the next
    // header picks up the new settings
    wait_drained();
    program_regs(16'd3, 16'h0055, 16'h1234, 1'b0);
    send_item(8'h33, 8'h44, 1'b1);
    send_item(8'h66, 8'h77, 1'b1);

    // Random phases, each with a fresh register setting; frames may stay open
    // across a phase boundary
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       cnt_d = 16'd0;
        1:       cnt_d = 16'd16;
        2:       cnt_d = 16'($urandom_range(1, 15));
        default: cnt_d = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       val_d = 16'h0000;
        1:       val_d = 16'hFFFF;
        default: val_d = 16'($urandom_range(0, 65535));
      endcase
      sync_d = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      program_regs(cnt_d, val_d, sync_d, 1'($urandom_range(0, 1)));
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Drain, then give a stray wire byte time to show up
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
